FILE: hdl/ftba_pkg.sv
// ----------------------------------------------------------------------------
// ftba_pkg
// Shared types, codes and constants of the frame-tagged bump allocator.
// ----------------------------------------------------------------------------
package ftba_pkg;

  // Field widths
  localparam int SIZE_W   = 24;  // request and handle size field
  localparam int OFF_W    = 27;  // offsets, fill levels and capacities
  localparam int FRAME_W  = 10;  // frame counter and handle frame tag
  localparam int HANDLE_W = 62;  // packed handle
  localparam int PAD_W    = 25;  // padded size, up to 2^24
  localparam int ALIGN_W  = 4;   // uniform alignment exponent
  localparam int RENDER_W = 3;   // render set field

  // Handle layout
  localparam int SIZE_LSB  = 28;
  localparam int SIZE_MSB  = 51;
  localparam int FRAME_LSB = 52;
  localparam int FRAME_MSB = 61;

  // Fixed region alignments (log2 bytes)
  localparam logic [ALIGN_W-1:0] VERTEX_ALIGN_LOG2 = ALIGN_W'(5);
  localparam logic [ALIGN_W-1:0] INDEX_ALIGN_LOG2  = ALIGN_W'(4);

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [OFF_W-1:0]   STATIC_CAP_RESET    = OFF_W'(67108864);
  localparam logic [OFF_W-1:0]   TRANSIENT_CAP_RESET = OFF_W'(2097152);
  localparam logic [OFF_W-1:0]   UNIFORM_CAP_RESET   = OFF_W'(2097152);
  localparam logic [ALIGN_W-1:0] ALIGN_LOG2_RESET    = ALIGN_W'(8);

  localparam int FRAMES_DEFAULT = 2;

  // Commands
  typedef enum logic [1:0] {
    CMD_ALLOC        = 2'd0,
    CMD_TICK         = 2'd1,
    CMD_QUERY        = 2'd2,
    CMD_CLEAR_STATIC = 2'd3
  } cmd_e_t;

  // Region codes
  localparam logic [1:0] KIND_VERTEX  = 2'd0;
  localparam logic [1:0] KIND_INDEX   = 2'd1;
  localparam logic [1:0] KIND_UNIFORM = 2'd2;

  // Register map
  typedef enum logic [1:0] {
    REG_STATIC_CAP    = 2'd0,
    REG_TRANSIENT_CAP = 2'd1,
    REG_UNIFORM_CAP   = 2'd2,
    REG_ALIGN_LOG2    = 2'd3
  } reg_e_t;

  typedef struct packed {
    logic [OFF_W-1:0]   static_cap;
    logic [OFF_W-1:0]   transient_cap;
    logic [OFF_W-1:0]   uniform_cap;
    logic [ALIGN_W-1:0] align_log2;
  } cfg_t;

  typedef struct packed {
    cmd_e_t              cmd;
    logic                pool_static;
    logic [1:0]          buffer_kind;
    logic [SIZE_W-1:0]   alloc_bytes;
    logic [HANDLE_W-1:0] query_handle;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] alloc_handle;
    logic                out_of_space;
    logic                handle_usable;
    logic                handle_current;
    logic                handle_static;
    logic [OFF_W-1:0]    handle_offset;
    logic [SIZE_W-1:0]   handle_size;
    logic [RENDER_W-1:0] render_set;
  } rsp_t;

endpackage

FILE: hdl/ftba_apb_regs.sv
// ----------------------------------------------------------------------------
// ftba_apb_regs
// APB-style configuration registers: capacities and uniform alignment.
// ----------------------------------------------------------------------------
module ftba_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ftba_pkg::ADDR_W-1:0] paddr,
  input  logic [ftba_pkg::DATA_W-1:0] pwdata,
  output logic [ftba_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output ftba_pkg::cfg_t              cfg
);

  ftba_pkg::reg_e_t sel;

  assign sel    = ftba_pkg::reg_e_t'(paddr[3:2]);
  assign pready = 1'b1;

  // Register write in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.static_cap    <= ftba_pkg::STATIC_CAP_RESET;
      cfg.transient_cap <= ftba_pkg::TRANSIENT_CAP_RESET;
      cfg.uniform_cap   <= ftba_pkg::UNIFORM_CAP_RESET;
      cfg.align_log2    <= ftba_pkg::ALIGN_LOG2_RESET;
    end else if (psel && penable && pwrite) begin
      case (sel)
        ftba_pkg::REG_STATIC_CAP:    cfg.static_cap    <= pwdata[ftba_pkg::OFF_W-1:0];
        ftba_pkg::REG_TRANSIENT_CAP: cfg.transient_cap <= pwdata[ftba_pkg::OFF_W-1:0];
        ftba_pkg::REG_UNIFORM_CAP:   cfg.uniform_cap   <= pwdata[ftba_pkg::OFF_W-1:0];
        ftba_pkg::REG_ALIGN_LOG2:    cfg.align_log2    <= pwdata[ftba_pkg::ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    case (sel)
      ftba_pkg::REG_STATIC_CAP:    prdata = ftba_pkg::DATA_W'(cfg.static_cap);
      ftba_pkg::REG_TRANSIENT_CAP: prdata = ftba_pkg::DATA_W'(cfg.transient_cap);
      ftba_pkg::REG_UNIFORM_CAP:   prdata = ftba_pkg::DATA_W'(cfg.uniform_cap);
      ftba_pkg::REG_ALIGN_LOG2:    prdata = ftba_pkg::DATA_W'(cfg.align_log2);
      default:                     prdata = '0;
    endcase
  end

endmodule

FILE: hdl/ftba_core.sv
// ----------------------------------------------------------------------------
// ftba_core
// Allocator state (frame counter, set pointers, fill levels) and the
// combinational command logic that reads and updates it.
// ----------------------------------------------------------------------------
module ftba_core #(
  parameter int FRAMES = ftba_pkg::FRAMES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  ftba_pkg::cfg_t cfg,
  input  logic           fire,
  input  ftba_pkg::req_t req,
  output ftba_pkg::rsp_t rsp
);

  localparam int SET_W = $clog2(FRAMES);

  logic [ftba_pkg::FRAME_W-1:0] frame_number;
  logic [SET_W-1:0]             active_set;
  logic [SET_W-1:0]             previous_set;
  logic [ftba_pkg::OFF_W-1:0]   static_fill    [3];
  logic [ftba_pkg::OFF_W-1:0]   transient_fill [FRAMES][3];

  logic [SET_W-1:0]             next_set;
  logic                         kind_ok;
  logic [1:0]                   region;
  logic [ftba_pkg::ALIGN_W-1:0] align_lg;
  logic [ftba_pkg::PAD_W-1:0]   round_sum;
  logic [ftba_pkg::PAD_W-1:0]   bytes;
  logic [ftba_pkg::PAD_W-1:0]   align_mask;
  logic [ftba_pkg::PAD_W-1:0]   pad_sum;
  logic [ftba_pkg::PAD_W-1:0]   padded;
  logic [ftba_pkg::OFF_W-1:0]   cap;
  logic [ftba_pkg::OFF_W-1:0]   cur_fill;
  logic [ftba_pkg::OFF_W:0]     end_pos;
  logic                         do_alloc;
  logic                         fits;
  logic [ftba_pkg::FRAME_W-1:0] prev_frame;
  logic [ftba_pkg::FRAME_W-1:0] tag;
  logic                         st;

  assign next_set = (active_set == SET_W'(FRAMES - 1)) ? '0 : active_set + SET_W'(1);

  // Region decode and size padding
  always_comb begin
    kind_ok  = 1'b1;
    region   = req.buffer_kind;
    align_lg = ftba_pkg::VERTEX_ALIGN_LOG2;
    case (req.buffer_kind)
      ftba_pkg::KIND_VERTEX:  align_lg = ftba_pkg::VERTEX_ALIGN_LOG2;
      ftba_pkg::KIND_INDEX:   align_lg = ftba_pkg::INDEX_ALIGN_LOG2;
      ftba_pkg::KIND_UNIFORM: align_lg = cfg.align_log2;
      default: begin
        kind_ok = 1'b0;
        region  = ftba_pkg::KIND_VERTEX;
      end
    endcase
  end

  assign round_sum  = {1'b0, req.alloc_bytes} + ftba_pkg::PAD_W'(15);
  assign bytes      = {round_sum[ftba_pkg::PAD_W-1:4], 4'b0000};
  assign align_mask = (ftba_pkg::PAD_W'(1) << align_lg) - ftba_pkg::PAD_W'(1);
  assign pad_sum    = bytes + align_mask;
  assign padded     = pad_sum & ~align_mask;

  // Capacity and current pointer of the selected region
  always_comb begin
    if (region == ftba_pkg::KIND_UNIFORM) cap = cfg.uniform_cap;
    else if (req.pool_static)             cap = cfg.static_cap;
    else                                  cap = cfg.transient_cap;
  end

  assign cur_fill = req.pool_static ? static_fill[region] : transient_fill[active_set][region];
  assign end_pos  = {1'b0, cur_fill} + (ftba_pkg::OFF_W + 1)'(padded);
  assign fits     = (end_pos <= {1'b0, cap});
  assign do_alloc = (req.cmd == ftba_pkg::CMD_ALLOC) && kind_ok && (req.alloc_bytes != '0);

  // Query fields
  assign st         = req.query_handle[0];
  assign tag        = req.query_handle[ftba_pkg::FRAME_MSB:ftba_pkg::FRAME_LSB];
  assign prev_frame = frame_number - ftba_pkg::FRAME_W'(1);

  // Result
  always_comb begin
    rsp = '0;
    case (req.cmd)
      ftba_pkg::CMD_ALLOC: begin
        if (do_alloc) begin
          if (fits) begin
            rsp.alloc_handle = {frame_number, bytes[ftba_pkg::SIZE_W-1:0], cur_fill,
                                req.pool_static};
          end else begin
            rsp.out_of_space = 1'b1;
          end
        end
      end
      ftba_pkg::CMD_QUERY: begin
        rsp.handle_usable  = st || (tag == prev_frame);
        rsp.handle_current = st || (tag == frame_number);
        rsp.handle_static  = st;
        rsp.handle_offset  = req.query_handle[ftba_pkg::OFF_W:1];
        rsp.handle_size    = req.query_handle[ftba_pkg::SIZE_MSB:ftba_pkg::SIZE_LSB];
      end
      default: ;
    endcase
    // render set reflects the rotation done by this item
    if (req.cmd == ftba_pkg::CMD_TICK) rsp.render_set = ftba_pkg::RENDER_W'(active_set);
    else                               rsp.render_set = ftba_pkg::RENDER_W'(previous_set);
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_number <= '0;
      active_set   <= '0;
      previous_set <= '0;
      for (int k = 0; k < 3; k++) static_fill[k] <= '0;
      for (int s = 0; s < FRAMES; s++)
        for (int k = 0; k < 3; k++) transient_fill[s][k] <= '0;
    end else if (fire) begin
      case (req.cmd)
        ftba_pkg::CMD_ALLOC: begin
          if (do_alloc && fits) begin
            if (req.pool_static) static_fill[region] <= end_pos[ftba_pkg::OFF_W-1:0];
            else transient_fill[active_set][region] <= end_pos[ftba_pkg::OFF_W-1:0];
          end
        end
        ftba_pkg::CMD_TICK: begin
          frame_number <= frame_number + ftba_pkg::FRAME_W'(1);
          previous_set <= active_set;
          active_set   <= next_set;
          for (int k = 0; k < 3; k++) transient_fill[next_set][k] <= '0;
        end
        ftba_pkg::CMD_CLEAR_STATIC: begin
          static_fill[ftba_pkg::KIND_VERTEX] <= '0;
          static_fill[ftba_pkg::KIND_INDEX]  <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/frame_tagged_bump_allocator.sv
// ----------------------------------------------------------------------------
// frame_tagged_bump_allocator
// Bump allocator for vertex, index and uniform regions with one static set
// and FRAMES per-frame transient sets, packed frame-tagged handles.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------
//  req      | in  | req_valid/req_ready | ftba_pkg::req_t (command item)
//  rsp      | out | rsp_valid/rsp_ready | ftba_pkg::rsp_t (one result per item)
//  config   | in  | psel/penable/pready | 4 registers at byte address 4*i
//
//  One item per cycle sustained while rsp_ready stays high; a result passes
//  through the input register, then the command logic into the result
//  register, before it can be taken.
//  The fill registers sit beside the command logic, so back-to-back items see
//  each other's updates with no hazard.
//  Reset clears the allocator state and both valid flags; no clearing pass.
//  A stalled result holds the input register; the result register and input
//  register together hold two items under back-pressure.
// ----------------------------------------------------------------------------
module frame_tagged_bump_allocator #(
  parameter int FRAMES = ftba_pkg::FRAMES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  ftba_pkg::req_t              req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output ftba_pkg::rsp_t              rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ftba_pkg::ADDR_W-1:0] paddr,
  input  logic [ftba_pkg::DATA_W-1:0] pwdata,
  output logic [ftba_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  ftba_pkg::cfg_t cfg;
  ftba_pkg::req_t s1_req;
  ftba_pkg::rsp_t s1_rsp;
  logic           s1_valid;
  logic           s1_adv;

  ftba_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ftba_core #(.FRAMES(FRAMES)) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (s1_adv),
    .req  (s1_req),
    .rsp  (s1_rsp)
  );

  // Stage advance: result register empty or being drained
  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1_req <= req;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= s1_rsp;
    end
  end

  // Checks
  a_oos_no_handle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.out_of_space |-> rsp.alloc_handle == '0)
    else $error("out_of_space result carries a handle");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> s1_valid && rsp_valid && !rsp_ready)
    else $error("input stalled while a stage is free");

  a_adv_fills: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> rsp_valid)
    else $error("advanced item did not reach the result register");

  a_usable_current: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.handle_usable && rsp.handle_current |-> rsp.handle_static)
    else $error("transient handle reported both previous and current frame");

endmodule
